// ----- rtl/core/int4_dq_pkg.sv -----
// Package with shared types and constants for the int4 dequantizer.
package int4_dq_pkg;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_INF   = 8'hFF;
    localparam logic [4:0]  HEXP_MAX  = 5'h1F;

    typedef struct packed {
        logic        sign;
        logic        is_inf;
        logic        dzero;
        logic [3:0]  dmag;
        logic [10:0] sig;
        logic [4:0]  eff;
    } t_s1;

    typedef struct packed {
        logic        sign;
        logic        is_inf;
        logic        dzero;
        logic [14:0] m;
        logic [4:0]  eff;
    } t_s2;
endpackage

// ----- rtl/core/int4_dq_decode.sv -----
// Stage one: nibble extraction, difference and half-precision field decode.
module int4_dq_decode import int4_dq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_weight_word,
    input  logic [31:0] i_zero_word,
    input  logic [15:0] i_scale_half,
    input  logic [2:0]  i_nibble_select,
    output logic        o_valid,
    output t_s1         o_data
);
    logic [3:0] wn, zn;
    logic       dneg;
    logic [4:0] hexp;
    t_s1        n_data, r_data;
    logic       r_valid;

    always_comb begin
        wn   = i_weight_word[{i_nibble_select, 2'b00} +: 4];
        zn   = i_zero_word[{i_nibble_select, 2'b00} +: 4];
        dneg = wn < zn;
        hexp = i_scale_half[14:10];
        n_data.sign   = dneg ^ i_scale_half[15];
        n_data.dmag   = dneg ? (zn - wn) : (wn - zn);
        n_data.dzero  = (wn == zn);
        n_data.is_inf = (hexp == HEXP_MAX);
        n_data.sig    = {(hexp != 5'd0), i_scale_half[9:0]};
        n_data.eff    = (hexp != 5'd0) ? hexp : 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else r_valid <= i_valid;
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- rtl/core/int4_dq_mul.sv -----
// Stage two: integer product of difference magnitude and scale significand.
module int4_dq_mul import int4_dq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_s1  i_data,
    output logic o_valid,
    output t_s2  o_data
);
    t_s2  r_data;
    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else r_valid <= i_valid;
        r_data.sign   <= i_data.sign;
        r_data.is_inf <= i_data.is_inf;
        r_data.dzero  <= i_data.dzero;
        r_data.eff    <= i_data.eff;
        r_data.m      <= {11'd0, i_data.dmag} * {4'd0, i_data.sig};
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ----- rtl/core/int4_dq_pack.sv -----
// Stage three: leading-one detection, normalization and single-precision packing.
module int4_dq_pack import int4_dq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_s2         i_data,
    output logic        o_valid,
    output logic [31:0] o_result
);
    logic [3:0]  p;
    logic [7:0]  bexp;
    logic [22:0] frac;
    logic [37:0] sh;
    logic [31:0] n_result, r_result;
    logic        r_valid;

    always_comb begin
        p = 4'd0;
        for (int i = 0; i < 15; i++) begin
            if (i_data.m[i]) p = 4'(i);
        end
        bexp = 8'(8'd102 + {4'd0, p} + {3'd0, i_data.eff});
        sh   = {23'd0, i_data.m} << (5'd23 - {1'b0, p});
        frac = sh[22:0];
        if (i_data.is_inf) begin
            n_result = i_data.dzero ? QNAN_BITS : {i_data.sign, EXP_INF, 23'd0};
        end else if (i_data.m == 15'd0) begin
            n_result = {i_data.sign, 31'd0};
        end else begin
            n_result = {i_data.sign, bexp, frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else r_valid <= i_valid;
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

// ----- rtl/core/int4_awq_dequantizer.sv -----
// Top level of the int4 AWQ dequantizer: three-stage pipeline.
// An accepted start passes through the decode, multiply and pack registers in turn before the o_done strobe.
// Throughput: one transaction per cycle; busy is always low.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Synchronous active-low reset clears the valid bits of all stages.
module int4_awq_dequantizer import int4_dq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_weight_word,
    input  logic [31:0] i_zero_word,
    input  logic [15:0] i_scale_half,
    input  logic [2:0]  i_nibble_select,
    output logic        o_done,
    output logic [31:0] o_weight_single
);
    logic v1, v2;
    t_s1  d1;
    t_s2  d2;

    assign busy = 1'b0;

    int4_dq_decode u_dec (
        .i_clk, .i_rst_n, .i_valid(start && !busy),
        .i_weight_word, .i_zero_word, .i_scale_half, .i_nibble_select,
        .o_valid(v1), .o_data(d1)
    );

    int4_dq_mul u_mul (
        .i_clk, .i_rst_n, .i_valid(v1), .i_data(d1), .o_valid(v2), .o_data(d2)
    );

    int4_dq_pack u_pack (
        .i_clk, .i_rst_n, .i_valid(v2), .i_data(d2),
        .o_valid(o_done), .o_result(o_weight_single)
    );

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> ##2 o_done) else $error("result strobe missing");
    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v2 && d2.is_inf && d2.dzero) |=> (o_weight_single == QNAN_BITS))
        else $error("zero times infinity not NaN");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v2 && !d2.is_inf && d2.m == 15'd0) |=> (o_weight_single[30:0] == 31'd0))
        else $error("zero product not zero");
endmodule
